// ===== design/jsu_pkg.sv =====
// ---------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ---------------------------------------------------------------------------
package jsu_pkg;

  // decoder mode between input bytes
  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_NUM  = 2'd2
  } esc_mode_t;

  localparam int MAX_RESULTS = 7;
  localparam int UTF8_MAX    = 6;
  localparam int ACC_W       = 31;

  localparam logic [ACC_W-1:0] ACC_MAX = 31'h7FFF_FFFF;

  // special characters
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_SEVEN     = 8'h37;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_LA        = 8'h61;
  localparam logic [7:0] CHAR_LF        = 8'h66;
  localparam logic [7:0] CHAR_UA        = 8'h41;
  localparam logic [7:0] CHAR_UF        = 8'h46;
  localparam logic [7:0] CHAR_U         = 8'h75;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_V         = 8'h76;
  localparam logic [7:0] CHAR_R         = 8'h72;

  // encoded utf-8 sequence, byte 0 goes out first
  typedef struct packed {
    logic [2:0]                    len;
    logic [UTF8_MAX-1:0][7:0]      bytes;
  } utf8_seq_t;

endpackage

// ===== design/jsu_utf8_enc.sv =====
// ---------------------------------------------------------------------------
// jsu_utf8_enc
// Encodes a 31-bit code point as 1 to 6 bytes of extended UTF-8.
// ---------------------------------------------------------------------------
module jsu_utf8_enc
  import jsu_pkg::*;
(
  input  logic [ACC_W-1:0] cp,
  output utf8_seq_t        seq
);

  logic [2:0]      tail;
  logic [4:0][5:0] sixes;
  logic [7:0]      lead;

  // number of continuation bytes
  always_comb begin
    if (cp < 31'h80) begin
      tail = 3'd0;
    end else if (cp < 31'h800) begin
      tail = 3'd1;
    end else if (cp < 31'h1_0000) begin
      tail = 3'd2;
    end else if (cp < 31'h20_0000) begin
      tail = 3'd3;
    end else if (cp < 31'h400_0000) begin
      tail = 3'd4;
    end else begin
      tail = 3'd5;
    end
  end

  // six-bit groups of the code point
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      sixes[k] = cp[6*k +: 6];
    end
  end

  // lead byte
  always_comb begin
    case (tail)
      3'd0:    lead = {1'b0, cp[6:0]};
      3'd1:    lead = 8'hC0 | {3'b000, cp[10:6]};
      3'd2:    lead = 8'hE0 | {4'b0000, cp[15:12]};
      3'd3:    lead = 8'hF0 | {5'b00000, cp[20:18]};
      3'd4:    lead = 8'hF8 | {6'b000000, cp[25:24]};
      default: lead = 8'hFC | {7'b0000000, cp[30]};
    endcase
  end

  // lead then continuation bytes, high group first
  always_comb begin
    seq.len   = tail + 3'd1;
    seq.bytes = '0;
    seq.bytes[0] = lead;
    for (int j = 1; j < UTF8_MAX; j++) begin
      if (3'(j) <= tail) begin
        seq.bytes[j] = 8'h80 | {2'b00, sixes[3'(tail - 3'(j))]};
      end
    end
  end

endmodule

// ===== design/json_string_unescape_utf8_core.sv =====
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_core
// JSON string body unescaper with extended UTF-8 output.
// ---------------------------------------------------------------------------
// Feed the bytes of a string body, after the opening quote, on in_byte with
// in_valid/in_ready. Each input transfer yields 0 to 7 results on out_byte,
// end_of_string and last_of_run with out_valid/out_ready; last_of_run marks
// the final result of one input byte, end_of_string marks the closing quote
// or NUL (out_byte is then zero) and the decoder is ready for a new body.
// Results are registered and show in the cycle after their input transfer.
// Throughput: one input byte per cycle while each byte gives at most one
// result and the receiver takes every result. A byte giving n results
// holds the output run register until all n have left, and the next byte is
// taken in the cycle its last result leaves. Bytes that give no result
// (backslash, escape openers, digits) leave the run register empty. On a
// stall the run register holds and in_ready stays low while it holds a result.
// Reset (rst, synchronous) returns the decoder to plain text and empties
// the run register.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8_core
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] out_byte,
  output logic       end_of_string,
  output logic       last_of_run,
  output logic       out_valid,
  input  logic       out_ready
);

  // decoder state
  esc_mode_t        mode, mode_next;
  logic             number_is_hex, number_is_hex_next;
  logic [ACC_W-1:0] acc, acc_next;

  // output run register
  logic [MAX_RESULTS-1:0][7:0] run_bytes;
  logic [2:0]                  run_cnt;
  logic                        run_eos;

  // results of the byte at the input
  logic [MAX_RESULTS-1:0][7:0] res_bytes;
  logic [2:0]                  res_cnt;
  logic                        res_eos;

  logic in_fire, out_fire;
  logic p_end, p_bs;
  logic [7:0] mapped;
  logic       mapped_ok;
  logic       digit_ok;
  logic [3:0] digit;
  utf8_seq_t  seq;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (run_cnt == 3'd0) || ((run_cnt == 3'd1) && out_ready);

  // plain text classes
  assign p_end = (in_byte == CHAR_QUOTE) || (in_byte == CHAR_NUL);
  assign p_bs  = (in_byte == CHAR_BACKSLASH);

  // single-character escapes
  always_comb begin
    mapped_ok = 1'b1;
    case (in_byte)
      CHAR_QUOTE:     mapped = CHAR_QUOTE;
      CHAR_SLASH:     mapped = CHAR_SLASH;
      CHAR_BACKSLASH: mapped = CHAR_BACKSLASH;
      CHAR_LA:        mapped = 8'd7;
      CHAR_B:         mapped = 8'd8;
      CHAR_T:         mapped = 8'd9;
      CHAR_N:         mapped = 8'd10;
      CHAR_V:         mapped = 8'd11;
      CHAR_LF:        mapped = 8'd12;
      CHAR_R:         mapped = 8'd13;
      default: begin
        mapped    = 8'd0;
        mapped_ok = 1'b0;
      end
    endcase
  end

  // digit decode in the current base
  always_comb begin
    digit_ok = 1'b0;
    digit    = 4'd0;
    if (number_is_hex) begin
      if (in_byte >= CHAR_ZERO && in_byte <= CHAR_NINE) begin
        digit_ok = 1'b1;
        digit    = 4'(in_byte - CHAR_ZERO);
      end else if (in_byte >= CHAR_LA && in_byte <= CHAR_LF) begin
        digit_ok = 1'b1;
        digit    = 4'(in_byte - CHAR_LA + 8'd10);
      end else if (in_byte >= CHAR_UA && in_byte <= CHAR_UF) begin
        digit_ok = 1'b1;
        digit    = 4'(in_byte - CHAR_UA + 8'd10);
      end
    end else if (in_byte >= CHAR_ZERO && in_byte <= CHAR_SEVEN) begin
      digit_ok = 1'b1;
      digit    = 4'(in_byte - CHAR_ZERO);
    end
  end

  jsu_utf8_enc u_enc (
    .cp  (acc),
    .seq (seq)
  );

  // next decoder state
  always_comb begin
    mode_next          = mode;
    number_is_hex_next = number_is_hex;
    acc_next           = acc;
    case (mode)
      MODE_ESC: begin
        mode_next = MODE_TEXT;
        if (in_byte == CHAR_NUL) begin
          number_is_hex_next = 1'b0;
          acc_next           = '0;
        end else if (in_byte == CHAR_ZERO || in_byte == CHAR_U) begin
          mode_next          = MODE_NUM;
          number_is_hex_next = (in_byte == CHAR_U);
          acc_next           = '0;
        end
      end
      MODE_NUM: begin
        if (digit_ok) begin
          if (number_is_hex) begin
            acc_next = (|acc[30:27]) ? ACC_MAX : {acc[26:0], digit};
          end else begin
            acc_next = (|acc[30:28]) ? ACC_MAX : {acc[27:0], digit[2:0]};
          end
        end else begin
          number_is_hex_next = 1'b0;
          acc_next           = '0;
          mode_next          = p_bs ? MODE_ESC : MODE_TEXT;
        end
      end
      default: begin
        if (p_end) begin
          mode_next          = MODE_TEXT;
          number_is_hex_next = 1'b0;
          acc_next           = '0;
        end else begin
          mode_next = p_bs ? MODE_ESC : MODE_TEXT;
        end
      end
    endcase
  end

  // result list of the byte at the input
  always_comb begin
    res_bytes = '0;
    res_cnt   = 3'd0;
    res_eos   = 1'b0;
    case (mode)
      MODE_ESC: begin
        if (in_byte == CHAR_NUL) begin
          res_cnt = 3'd1;
          res_eos = 1'b1;
        end else if (mapped_ok) begin
          res_cnt      = 3'd1;
          res_bytes[0] = mapped;
        end
      end
      MODE_NUM: begin
        if (!digit_ok) begin
          for (int i = 0; i < UTF8_MAX; i++) begin
            if (3'(i) < seq.len) begin
              res_bytes[i] = seq.bytes[i];
            end
          end
          res_cnt = seq.len;
          if (p_end) begin
            res_bytes[seq.len] = 8'd0;
            res_eos            = 1'b1;
            res_cnt            = seq.len + 3'd1;
          end else if (!p_bs) begin
            res_bytes[seq.len] = in_byte;
            res_cnt            = seq.len + 3'd1;
          end
        end
      end
      default: begin
        if (p_end) begin
          res_cnt = 3'd1;
          res_eos = 1'b1;
        end else if (!p_bs) begin
          res_cnt      = 3'd1;
          res_bytes[0] = in_byte;
        end
      end
    endcase
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_TEXT;
      number_is_hex <= 1'b0;
      acc           <= '0;
    end else if (in_fire) begin
      mode          <= mode_next;
      number_is_hex <= number_is_hex_next;
      acc           <= acc_next;
    end
  end

  // run count
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= 3'd0;
    end else if (in_fire) begin
      run_cnt <= res_cnt;
    end else if (out_fire) begin
      run_cnt <= run_cnt - 3'd1;
    end
  end

  // run payload, shifted down on each output transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      run_bytes <= res_bytes;
      run_eos   <= res_eos;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        run_bytes[i] <= run_bytes[i+1];
      end
      run_bytes[MAX_RESULTS-1] <= 8'd0;
    end
  end

  assign out_valid     = (run_cnt != 3'd0);
  assign out_byte      = run_bytes[0];
  assign last_of_run   = (run_cnt == 3'd1);
  assign end_of_string = run_eos && (run_cnt == 3'd1);

  // checks
  a_eos_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_string) |-> last_of_run)
    else $error("end of string not on last result");

  a_eos_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_string) |-> (out_byte == 8'd0))
    else $error("end of string carries data");

  a_eos_text: assert property (@(posedge clk) disable iff (rst)
    (out_fire && end_of_string) |-> (mode == MODE_TEXT && acc == '0))
    else $error("decoder not cleared at end of string");

  a_take_run: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_cnt != 3'd0) |=> (out_valid && run_cnt == $past(res_cnt)))
    else $error("result run not loaded");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON string unescaper. Directed escapes and
// terminators first, then random well-formed bodies (plain text, escapes,
// octal and hex numbers that may saturate) mixed with noise. Random results
// come from a behavioral decoder; all run under random stalls on both channels.
// ---------------------------------------------------------------------------
module tb;
  import jsu_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 4;
  localparam int ERR_SHOWN    = 10;
  localparam int RAND_ITEMS   = 300;

  // control bytes produced by the single-character escapes
  localparam logic [7:0] CTRL_BEL = 8'h07;
  localparam logic [7:0] CTRL_BS  = 8'h08;
  localparam logic [7:0] CTRL_HT  = 8'h09;
  localparam logic [7:0] CTRL_NL  = 8'h0A;
  localparam logic [7:0] CTRL_VT  = 8'h0B;
  localparam logic [7:0] CTRL_FF  = 8'h0C;
  localparam logic [7:0] CTRL_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LQ  = 8'h71;

  localparam logic [7:0] SIMPLE_ESC [10] = '{CHAR_QUOTE, CHAR_SLASH, CHAR_BACKSLASH,
    CHAR_LA, CHAR_B, CHAR_T, CHAR_N, CHAR_V, CHAR_LF, CHAR_R};

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       last;
  } dec_result_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_DATA,
    ROW_END
  } row_kind_t;

  typedef struct packed {
    logic [7:0] b;
    row_kind_t  kind;
    logic [7:0] data;
  } stim_row_t;

  // directed bytes; obvious results typed in, the rest go to the decoder model
  localparam stim_row_t DIRECTED [32] = '{
    '{CHAR_UA,        ROW_DATA,    CHAR_UA},
    '{8'hFF,          ROW_DATA,    8'hFF},
    '{8'h01,          ROW_DATA,    8'h01},
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_QUOTE,     ROW_DATA,    CHAR_QUOTE},
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_SLASH,     ROW_DATA,    CHAR_SLASH},
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_BACKSLASH, ROW_DATA,    CHAR_BACKSLASH},
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_LA,        ROW_DATA,    CTRL_BEL},
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_B,         ROW_DATA,    CTRL_BS},
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_T,         ROW_DATA,    CTRL_HT},
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_N,         ROW_DATA,    CTRL_NL},
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_V,         ROW_DATA,    CTRL_VT},
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_LF,        ROW_DATA,    CTRL_FF},
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_R,         ROW_DATA,    CTRL_CR},
    // unknown escape is dropped
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_LQ,        ROW_NONE,    8'h00},
    // nul right after a backslash closes the string
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_NUL,       ROW_END,     8'h00},
    // hex number with no digits, closed by a quote
    '{CHAR_BACKSLASH, ROW_NONE,    8'h00},
    '{CHAR_U,         ROW_NONE,    8'h00},
    '{CHAR_QUOTE,     ROW_PREDICT, 8'h00},
    '{CHAR_NUL,       ROW_END,     8'h00},
    '{CHAR_QUOTE,     ROW_END,     8'h00}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic [7:0] in_byte;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] out_byte;
  logic       end_of_string;
  logic       last_of_run;
  logic       out_valid;
  logic       out_ready;

  // decoder model state
  esc_mode_t        dec_mode;
  logic             dec_hex;
  logic [ACC_W-1:0] dec_acc;

  dec_result_t run_q[$];
  dec_result_t decoded_q[$];

  int errors = 0;
  int rand_items;
  int cycle_count = 0;
  int squeeze_cnt;
  bit tx_calm;
  bit rx_calm;

  json_string_unescape_utf8_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (in_byte),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_byte     (out_byte),
    .end_of_string(end_of_string),
    .last_of_run  (last_of_run),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic void clear_decoder();
    dec_mode = MODE_TEXT;
    dec_hex  = 1'b0;
    dec_acc  = '0;
  endfunction

  function automatic void emit(input logic [7:0] d, input logic eos);
    run_q.push_back('{data: d, eos: eos, last: 1'b0});
  endfunction

  // extended utf-8, lead byte first
  function automatic void emit_utf8(input logic [ACC_W-1:0] cp);
    int         tail;
    logic [7:0] lead;
    if (cp < 'h80) begin
      emit(cp[7:0], 1'b0);
      return;
    end
    if (cp < 'h800) begin
      tail = 1; lead = 8'hC0 | 8'(cp >> 6);
    end else if (cp < 'h10000) begin
      tail = 2; lead = 8'hE0 | 8'(cp >> 12);
    end else if (cp < 'h200000) begin
      tail = 3; lead = 8'hF0 | 8'(cp >> 18);
    end else if (cp < 'h4000000) begin
      tail = 4; lead = 8'hF8 | 8'(cp >> 24);
    end else begin
      tail = 5; lead = 8'hFC | 8'(cp >> 30);
    end
    emit(lead, 1'b0);
    for (int i = tail - 1; i >= 0; i--)
      emit(8'h80 | (8'(cp >> (6 * i)) & 8'h3F), 1'b0);
  endfunction

  function automatic void text_byte(input logic [7:0] b);
    if (b == CHAR_QUOTE || b == CHAR_NUL) begin
      emit(8'h00, 1'b1);
      clear_decoder();
    end else if (b == CHAR_BACKSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      emit(b, 1'b0);
      dec_mode = MODE_TEXT;
    end
  endfunction

  function automatic int digit_of(input logic [7:0] b, input logic hex);
    if (!hex)
      return (b >= CHAR_ZERO && b <= CHAR_SEVEN) ? int'(b - CHAR_ZERO) : -1;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) return int'(b - CHAR_ZERO);
    if (b >= CHAR_LA && b <= CHAR_LF) return int'(b - CHAR_LA) + 10;
    if (b >= CHAR_UA && b <= CHAR_UF) return int'(b - CHAR_UA) + 10;
    return -1;
  endfunction

  // results of one input byte into run_q, last one flagged
  function automatic void decode_byte(input logic [7:0] b);
    int          d;
    logic [63:0] grown;
    run_q.delete();
    case (dec_mode)
      MODE_ESC: begin
        dec_mode = MODE_TEXT;
        case (b)
          CHAR_NUL: begin
            emit(8'h00, 1'b1);
            clear_decoder();
          end
          CHAR_ZERO: begin
            dec_mode = MODE_NUM; dec_hex = 1'b0; dec_acc = '0;
          end
          CHAR_U: begin
            dec_mode = MODE_NUM; dec_hex = 1'b1; dec_acc = '0;
          end
          CHAR_QUOTE, CHAR_SLASH, CHAR_BACKSLASH: emit(b, 1'b0);
          CHAR_LA: emit(CTRL_BEL, 1'b0);
          CHAR_B:  emit(CTRL_BS, 1'b0);
          CHAR_T:  emit(CTRL_HT, 1'b0);
          CHAR_N:  emit(CTRL_NL, 1'b0);
          CHAR_V:  emit(CTRL_VT, 1'b0);
          CHAR_LF: emit(CTRL_FF, 1'b0);
          CHAR_R:  emit(CTRL_CR, 1'b0);
          default: ;  // unknown escape, nothing out
        endcase
      end
      MODE_NUM: begin
        d = digit_of(b, dec_hex);
        if (d >= 0) begin
          grown = 64'(dec_acc) * (dec_hex ? 64'd16 : 64'd8) + 64'(d);
          dec_acc = (grown > 64'(ACC_MAX)) ? ACC_MAX : ACC_W'(grown);
        end else begin
          // code point goes first, then the ending byte as plain text
          emit_utf8(dec_acc);
          clear_decoder();
          text_byte(b);
        end
      end
      default: begin
        dec_mode = MODE_TEXT;
        text_byte(b);
      end
    endcase
    if (run_q.size() > 0)
      run_q[run_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void queue_run();
    foreach (run_q[i])
      decoded_q.push_back(run_q[i]);
  endfunction

  // one input transfer, with a random gap ahead of it
  task automatic transfer_byte(input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_predicted(input logic [7:0] b);
    transfer_byte(b);
    decode_byte(b);
    queue_run();
    rand_items++;
  endtask

  // sender stops offering until every pending result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one random fragment of a string body
  task automatic send_sequence();
    logic [7:0] seq[$];
    logic [7:0] b;
    int         pick;
    int         ndig;
    int         v;
    logic       hex;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      repeat ($urandom_range(1, 4)) begin
        do b = 8'($urandom_range(1, 255)); while (b == CHAR_QUOTE || b == CHAR_BACKSLASH);
        seq.push_back(b);
      end
    end else if (pick < 50) begin
      seq.push_back(CHAR_BACKSLASH);
      seq.push_back(SIMPLE_ESC[$urandom_range(0, 9)]);
    end else if (pick < 70) begin
      // octal or hex number, long ones may saturate
      hex = 1'($urandom_range(0, 1));
      seq.push_back(CHAR_BACKSLASH);
      seq.push_back(hex ? CHAR_U : CHAR_ZERO);
      ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      repeat (ndig) begin
        if (!hex) begin
          seq.push_back(CHAR_ZERO + 8'($urandom_range(0, 7)));
        end else begin
          v = $urandom_range(0, 15);
          if (v < 10)
            seq.push_back(CHAR_ZERO + 8'(v));
          else
            seq.push_back(($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + 8'(v - 10));
        end
      end
    end else if (pick < 80) begin
      seq.push_back($urandom_range(0, 1) ? CHAR_QUOTE : CHAR_NUL);
    end else if (pick < 90) begin
      seq.push_back(CHAR_BACKSLASH);
      seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[i])
      send_predicted(seq[i]);
  endtask

  task automatic check_result();
    dec_result_t want;
    if (decoded_q.size() == 0) begin
      errors++;
      if (errors <= ERR_SHOWN)
        $display("mismatch: unexpected result byte=%02h eos=%0b last=%0b",
                 out_byte, end_of_string, last_of_run);
    end else begin
      want = decoded_q.pop_front();
      if (want.data !== out_byte || want.eos !== end_of_string || want.last !== last_of_run) begin
        errors++;
        if (errors <= ERR_SHOWN)
          $display("mismatch: exp byte=%02h eos=%0b last=%0b got byte=%02h eos=%0b last=%0b",
                   want.data, want.eos, want.last, out_byte, end_of_string, last_of_run);
      end
    end
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    int stall;
    int squeeze_seen;
    out_ready    = 1'b0;
    rx_calm      = 1'b0;
    squeeze_seen = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (squeeze_cnt != squeeze_seen) begin
        squeeze_seen = squeeze_cnt;
        stall = HOLD_CYCLES;
      end else begin
        if ($urandom_range(0, 15) == 0)
          rx_calm = !rx_calm;
        stall = rx_calm ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result();
    end
  end

  // sender and end of run
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    rand_items  = 0;
    tx_calm     = 1'b0;
    squeeze_cnt = 0;
    clear_decoder();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (DIRECTED[i]) begin
      transfer_byte(DIRECTED[i].b);
      decode_byte(DIRECTED[i].b);
      case (DIRECTED[i].kind)
        ROW_PREDICT: queue_run();
        ROW_DATA:    decoded_q.push_back('{data: DIRECTED[i].data, eos: 1'b0, last: 1'b1});
        ROW_END:     decoded_q.push_back('{data: 8'h00, eos: 1'b1, last: 1'b1});
        default:     ;
      endcase
    end
    wait_drained();

    // random bodies
    while (rand_items < RAND_ITEMS / 2) begin
      tx_calm = ($urandom_range(0, 5) == 0);
      send_sequence();
    end

    // back-to-back input while the receiver holds off
    tx_calm     = 1'b1;
    squeeze_cnt = squeeze_cnt + 1;
    repeat (12) send_sequence();
    wait_drained();

    while (rand_items < RAND_ITEMS) begin
      tx_calm = ($urandom_range(0, 5) == 0);
      send_sequence();
    end
    wait_drained();

    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
